>>> rtl/core/chacha20_block_function_core_macros.svh
// Assertion macros used by the ChaCha20 block function core checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef CHACHA20_BLOCK_FUNCTION_CORE_MACROS_SVH
`define CHACHA20_BLOCK_FUNCTION_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define CBF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included
`define CBF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> rtl/core/cbf_pkg.sv
// Shared types, constants and round functions for the ChaCha20 block function core.
// No dependencies; the interfaces, front, queue, back and top level of the core import this package.
`timescale 1ns / 1ps

package cbf_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_LEN   = 16;
   localparam int INDEX_W     = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int KEY_LEN     = 8;
   localparam int NONCE_LEN   = 3;

   // Queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [BLOCK_LEN-1:0] state_type;
   typedef logic [INDEX_W-1:0] index_type;

   localparam index_type LAST_INDEX = INDEX_W'(BLOCK_LEN - 1);

   // Constant words "expand 32-byte k"
   localparam word_type SIGMA_0 = 32'h61707865;
   localparam word_type SIGMA_1 = 32'h3320646e;
   localparam word_type SIGMA_2 = 32'h79622d32;
   localparam word_type SIGMA_3 = 32'h6b206574;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_01   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_23   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_45   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_67   = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_01 = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_2  = 8'd5;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_ROUND,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quarter_type;

   function automatic word_type rotl(word_type x, int unsigned r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic quarter_type qr_mix(quarter_type q);
      quarter_type r;
      r   = q;
      r.a = r.a + r.b;  r.d = rotl(r.d ^ r.a, 16);
      r.c = r.c + r.d;  r.b = rotl(r.b ^ r.c, 12);
      r.a = r.a + r.b;  r.d = rotl(r.d ^ r.a, 8);
      r.c = r.c + r.d;  r.b = rotl(r.b ^ r.c, 7);
      return r;
   endfunction

   // Apply one quarter round at four state positions
   function automatic state_type qr_at(state_type s, index_type ia, index_type ib,
                                       index_type ic, index_type id);
      state_type   r;
      quarter_type q;
      q = qr_mix(quarter_type'{s[ia], s[ib], s[ic], s[id]});
      r = s;
      r[ia] = q.a;
      r[ib] = q.b;
      r[ic] = q.c;
      r[id] = q.d;
      return r;
   endfunction

   // Column round or diagonal round; the four quarter rounds touch disjoint words
   function automatic state_type half_round(state_type s, logic diag);
      state_type r;
      r = s;
      if (diag) begin
         r = qr_at(r, 4'd0, 4'd5, 4'd10, 4'd15);
         r = qr_at(r, 4'd1, 4'd6, 4'd11, 4'd12);
         r = qr_at(r, 4'd2, 4'd7, 4'd8,  4'd13);
         r = qr_at(r, 4'd3, 4'd4, 4'd9,  4'd14);
      end else begin
         r = qr_at(r, 4'd0, 4'd4, 4'd8,  4'd12);
         r = qr_at(r, 4'd1, 4'd5, 4'd9,  4'd13);
         r = qr_at(r, 4'd2, 4'd6, 4'd10, 4'd14);
         r = qr_at(r, 4'd3, 4'd7, 4'd11, 4'd15);
      end
      return r;
   endfunction

endpackage

>>> rtl/core/cbf_req_if.sv
// Request channel: one block counter per transaction.
// Depends on cbf_pkg.
`timescale 1ns / 1ps

interface cbf_req_if;
   import cbf_pkg::*;

   logic     valid;
   logic     ready;
   word_type block_counter;

   modport source (output valid, output block_counter, input ready);
   modport sink   (input valid, input block_counter, output ready);
endinterface

>>> rtl/core/cbf_rsp_if.sv
// Response channel: one keystream word per transaction with index and last flag.
// Depends on cbf_pkg.
`timescale 1ns / 1ps

interface cbf_rsp_if;
   import cbf_pkg::*;

   logic      valid;
   logic      ready;
   index_type word_index;
   word_type  keystream_word;
   logic      last;

   modport source (output valid, output word_index, output keystream_word, output last,
                   input ready);
   modport sink   (input valid, input word_index, input keystream_word, input last,
                   output ready);
endinterface

>>> rtl/core/cbf_front.sv
// Front end: holds key and nonce registers, accepts counters, builds initial states.
// Depends on cbf_pkg and cbf_req_if.
`timescale 1ns / 1ps

module cbf_front (
   input  logic                             clock,
   input  logic                             reset,
   cbf_req_if.sink                          req_bus,
   input  logic                             csr_we,
   input  logic [cbf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  cbf_pkg::queue_status_type        status,
   output logic                             push,
   output cbf_pkg::state_type               push_state
);
   import cbf_pkg::*;

   word_type [KEY_LEN-1:0]   key_ff,   key_in;
   word_type [NONCE_LEN-1:0] nonce_ff, nonce_in;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      key_in   = key_ff;
      nonce_in = nonce_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_01: begin
               key_in[0] = csr_wdata[WORD_W-1:0];
               key_in[1] = csr_wdata[CSR_DATA_W-1:WORD_W];
            end
            CSR_KEY_23: begin
               key_in[2] = csr_wdata[WORD_W-1:0];
               key_in[3] = csr_wdata[CSR_DATA_W-1:WORD_W];
            end
            CSR_KEY_45: begin
               key_in[4] = csr_wdata[WORD_W-1:0];
               key_in[5] = csr_wdata[CSR_DATA_W-1:WORD_W];
            end
            CSR_KEY_67: begin
               key_in[6] = csr_wdata[WORD_W-1:0];
               key_in[7] = csr_wdata[CSR_DATA_W-1:WORD_W];
            end
            CSR_NONCE_01: begin
               nonce_in[0] = csr_wdata[WORD_W-1:0];
               nonce_in[1] = csr_wdata[CSR_DATA_W-1:WORD_W];
            end
            CSR_NONCE_2: begin
               nonce_in[2] = csr_wdata[WORD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         nonce_ff <= '0;
      end else begin
         key_ff   <= key_in;
         nonce_ff <= nonce_in;
      end
   end

   // Accept whenever the queue has room
   assign req_bus.ready = !status.full;
   assign push          = req_bus.valid && req_bus.ready;

   // Lay out constants, key, counter and nonce
   always_comb begin
      push_state[0]  = SIGMA_0;
      push_state[1]  = SIGMA_1;
      push_state[2]  = SIGMA_2;
      push_state[3]  = SIGMA_3;
      for (int i = 0; i < KEY_LEN; i++) begin
         push_state[4 + i] = key_ff[i];
      end
      push_state[12] = req_bus.block_counter;
      for (int i = 0; i < NONCE_LEN; i++) begin
         push_state[13 + i] = nonce_ff[i];
      end
   end

endmodule

>>> rtl/core/cbf_queue.sv
// Short FIFO of initial states between the front end and the round engine.
// Depends on cbf_pkg.
`timescale 1ns / 1ps

module cbf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cbf_pkg::state_type        push_state,
   input  logic                      pop,
   output cbf_pkg::state_type        pop_state,
   output cbf_pkg::queue_status_type status
);
   import cbf_pkg::*;

   localparam logic [QUEUE_PTR_W:0] FULL_COUNT = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W:0] ONE_COUNT  = (QUEUE_PTR_W + 1)'(1);
   localparam logic [QUEUE_PTR_W-1:0] ONE_PTR  = QUEUE_PTR_W'(1);

   state_type [QUEUE_DEPTH-1:0] entry_ff, entry_in;
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]        count_ff, count_in;
   logic                        do_push, do_pop;

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_state    = entry_ff[rd_ptr_ff];

   // Advance pointers; they wrap naturally at a power-of-two depth
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_state;
         wr_ptr_in           = wr_ptr_ff + ONE_PTR;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + ONE_PTR;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + ONE_COUNT;
         2'b01:   count_in = count_ff - ONE_COUNT;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/core/cbf_back.sv
// Back end: round engine, final addition and word-by-word output buffer.
// Depends on cbf_pkg and cbf_rsp_if.
`timescale 1ns / 1ps

module cbf_back #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cbf_pkg::queue_status_type status,
   input  cbf_pkg::state_type        pop_state,
   output logic                      pop,
   cbf_rsp_if.source                 rsp_bus
);
   import cbf_pkg::*;

   localparam int              HALF_COUNT = 2 * DOUBLE_ROUNDS;
   localparam int              HALF_W     = (HALF_COUNT > 1) ? $clog2(HALF_COUNT) : 1;
   localparam logic [HALF_W-1:0] LAST_HALF = HALF_W'(HALF_COUNT - 1);
   localparam logic [HALF_W-1:0] ONE_HALF  = HALF_W'(1);

   eng_state_type     eng_state_ff, eng_state_in;
   logic [HALF_W-1:0] half_ff, half_in;
   state_type         work_ff, work_in;
   state_type         init_ff, init_in;
   logic              out_valid_ff, out_valid_in;
   index_type         out_idx_ff, out_idx_in;
   state_type         out_words_ff, out_words_in;
   logic              rsp_take, out_free, transfer;

   assign rsp_take = out_valid_ff && rsp_bus.ready;
   assign out_free = !out_valid_ff || (rsp_take && (out_idx_ff == LAST_INDEX));

   // Round engine: one column or diagonal round per cycle
   always_comb begin
      eng_state_in = eng_state_ff;
      half_in      = half_ff;
      work_in      = work_ff;
      init_in      = init_ff;
      pop          = 1'b0;
      transfer     = 1'b0;
      unique case (eng_state_ff)
         ENG_IDLE: begin
            if (!status.empty) begin
               pop          = 1'b1;
               work_in      = pop_state;
               init_in      = pop_state;
               half_in      = '0;
               eng_state_in = ENG_ROUND;
            end
         end
         ENG_ROUND: begin
            work_in = half_round(work_ff, half_ff[0]);
            if (half_ff == LAST_HALF) begin
               eng_state_in = ENG_DONE;
            end else begin
               half_in = half_ff + ONE_HALF;
            end
         end
         ENG_DONE: begin
            // Hand the block to the output buffer, then load the next one at once
            if (out_free) begin
               transfer = 1'b1;
               if (!status.empty) begin
                  pop          = 1'b1;
                  work_in      = pop_state;
                  init_in      = pop_state;
                  half_in      = '0;
                  eng_state_in = ENG_ROUND;
               end else begin
                  eng_state_in = ENG_IDLE;
               end
            end
         end
         default: begin
            eng_state_in = ENG_IDLE;
         end
      endcase
   end

   // Output buffer: add the initial state and step through the sixteen words
   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_words_in = out_words_ff;
      if (rsp_take) begin
         if (out_idx_ff == LAST_INDEX) begin
            out_valid_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + INDEX_W'(1);
         end
      end
      if (transfer) begin
         out_valid_in = 1'b1;
         out_idx_in   = '0;
         for (int i = 0; i < BLOCK_LEN; i++) begin
            out_words_in[i] = work_ff[i] + init_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_state_ff <= ENG_IDLE;
         half_ff      <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         eng_state_ff <= eng_state_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      init_ff      <= init_in;
      out_words_ff <= out_words_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.word_index     = out_idx_ff;
   assign rsp_bus.keystream_word = out_words_ff[out_idx_ff];
   assign rsp_bus.last           = (out_idx_ff == LAST_INDEX);

endmodule

>>> rtl/core/chacha20_block_function_core.sv
// ChaCha20 block function core: each request transaction carries a 32-bit block counter and
// yields sixteen response transactions, the keystream words 0 to 15 of that block, with the
// last flag on word 15. Key and nonce come from six registers written on the csr_ port; the
// user writes them while the core is idle, which the core itself does not enforce. A counter
// enters a two-entry queue in the cycle it is accepted; with the engine idle it is loaded in
// the following cycle, and the round engine then computes one column or diagonal round of
// four parallel quarter rounds per cycle. Once the output buffer is free, the ENG_DONE state
// hands the block to it and loads the next queued counter at once, so the engine works on one
// block while the output buffer streams the previous block's sixteen words in parallel.
// Depends on cbf_pkg, cbf_req_if, cbf_rsp_if, cbf_front, cbf_queue and cbf_back.
`timescale 1ns / 1ps

module chacha20_block_function_core #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   cbf_req_if.sink                          req_bus,
   cbf_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [cbf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cbf_pkg::*;

   logic             push;
   state_type        push_state;
   logic             pop;
   state_type        pop_state;
   queue_status_type status;

   cbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .push       (push),
      .push_state (push_state)
   );

   cbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_state (push_state),
      .pop        (pop),
      .pop_state  (pop_state),
      .status     (status)
   );

   cbf_back #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .pop_state (pop_state),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> rtl/core/cbf_checker.sv
// Port-level checks of the response stream, bound to the top level.
// Depends on chacha20_block_function_core_macros.svh and chacha20_block_function_core.
`timescale 1ns / 1ps
`include "chacha20_block_function_core_macros.svh"

module cbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  word_index,
   input logic [31:0] keystream_word,
   input logic        last
);

   logic        mid_take;
   logic        stalled;
   logic [3:0]  nxt_idx;
   logic [35:0] rsp_payload;

   // Classify the current cycle of the response channel
   assign mid_take    = rsp_valid && rsp_ready && !last;
   assign stalled     = rsp_valid && !rsp_ready;
   assign nxt_idx     = word_index + 4'd1;
   assign rsp_payload = {word_index, keystream_word};

   // Drop all output right after reset
   `CBF_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response valid after reset")

   // Flag the last word exactly at index fifteen
   `CBF_ASSERT(a_last_at_end, rsp_valid |-> (last == (word_index == 4'd15)), "last flag misplaced")

   // Follow a taken word inside a block with the next index
   `CBF_ASSERT(a_index_step, mid_take |=> rsp_valid && word_index == $past(nxt_idx), "index skip")

   // Hold a stalled word
   `CBF_ASSERT(a_stall_hold, stalled |=> rsp_valid && $stable(rsp_payload), "stall changed word")

endmodule

bind chacha20_block_function_core cbf_checker u_cbf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .word_index     (rsp_bus.word_index),
   .keystream_word (rsp_bus.keystream_word),
   .last           (rsp_bus.last)
);
